### sv/pbts_pkg.sv
// Package for the priority bitmap task scheduler.
// Holds the item and result structs, the event kind codes and the decoded
// command type shared by the front end and the execution back end.
package pbts_pkg;

  // Event kind codes as they arrive on the input channel.
  localparam logic [2:0] KIND_CREATE = 3'd0;
  localparam logic [2:0] KIND_TICK   = 3'd1;
  localparam logic [2:0] KIND_DELAY  = 3'd2;
  localparam logic [2:0] KIND_LOCK   = 3'd3;
  localparam logic [2:0] KIND_UNLOCK = 3'd4;

  // The lock count stops counting here.
  localparam logic [7:0] LOCK_MAX = 8'd255;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  prio;
    logic [31:0] ticks;
  } pbts_in_t;

  typedef struct packed {
    logic [4:0]  run_prio;
    logic        run_valid;
    logic        switched;
    logic [7:0]  lock_level;
    logic [31:0] ready_mask;
  } pbts_out_t;

  // Operations after classification by the front end.
  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_TICK   = 3'd1,
    OP_DELAY  = 3'd2,
    OP_LOCK   = 3'd3,
    OP_UNLOCK = 3'd4,
    OP_NOP    = 3'd5
  } pbts_op_t;

  typedef struct packed {
    pbts_op_t    op;
    logic [4:0]  prio;
    logic [31:0] ticks;
  } pbts_cmd_t;

endpackage

### sv/priority_bitmap_task_scheduler.sv
// Top level of the priority bitmap task scheduler.
// Instantiates pbts_front and pbts_back; types come from pbts_pkg.
//
//   Events enter on the input queue port: drive in_item and raise in_push;
//   the item is taken at a clock edge where in_push is high and in_full is
//   low. Kinds are create, tick, delay of the running task, lock and unlock.
//   Every item produces exactly one result, shown on out_item while
//   out_empty is low and removed at an edge where out_pop is high.
//   A two-entry command queue separates the front end from the execution
//   unit, so new items are taken while a result waits to be popped.
//   Create, lock, unlock and unknown kinds load their result directly;
//   delay and the unlock that releases the last lock level pass through a
//   reschedule state first; a tick walks the delay counter memory one
//   entry per cycle through its single read port and then reschedules.
//   The execution unit takes no new command until the last one has
//   produced its result, so that walk sets the sustained throughput.
//   Reset (rst_n low, synchronous) empties both queues, clears the bitmaps
//   and lock count and leaves the idle task running; no clearing pass is
//   needed. When the receiver stalls, the held result stays put, the
//   execution unit stops before producing another, and in_full rises.
module priority_bitmap_task_scheduler #(
  parameter int PRIO_COUNT  = 32,
  parameter int DELAY_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  pbts_pkg::pbts_in_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output pbts_pkg::pbts_out_t out_item
);
  import pbts_pkg::*;

  logic      cmd_valid;
  logic      cmd_pop;
  pbts_cmd_t cmd;

  pbts_front #(
    .PRIO_COUNT(PRIO_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd)
  );

  pbts_back #(
    .PRIO_COUNT (PRIO_COUNT),
    .DELAY_WIDTH(DELAY_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

endmodule

### sv/pbts_front.sv
// Front end of the task scheduler: accepts items, classifies them into
// commands and holds them in a two-entry queue for the back end.
// Depends on pbts_pkg.
module pbts_front #(
  parameter int PRIO_COUNT = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  pbts_pkg::pbts_in_t in_item,
  output logic              cmd_valid,
  input  logic              cmd_pop,
  output pbts_pkg::pbts_cmd_t cmd
);
  import pbts_pkg::*;

  pbts_cmd_t  q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push_ok;
  logic       pop_ok;
  pbts_cmd_t  dec;

  assign in_full   = (count_r == 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  // Classification; a create for a slot beyond the last priority is dropped.
  always_comb begin
    dec.prio  = in_item.prio;
    dec.ticks = in_item.ticks;
    case (in_item.kind)
      KIND_CREATE: begin
        if ({1'b0, in_item.prio} < 6'(PRIO_COUNT)) begin
          dec.op = OP_CREATE;
        end else begin
          dec.op = OP_NOP;
        end
      end
      KIND_TICK:   dec.op = OP_TICK;
      KIND_DELAY:  dec.op = OP_DELAY;
      KIND_LOCK:   dec.op = OP_LOCK;
      KIND_UNLOCK: dec.op = OP_UNLOCK;
      default:     dec.op = OP_NOP;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push_ok ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push_ok) - 2'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

### sv/pbts_back.sv
// Back end of the task scheduler: executes commands against the bitmaps,
// the delay counter memory and the lock count, and holds the result register.
// Depends on pbts_pkg.
module pbts_back #(
  parameter int PRIO_COUNT  = 32,
  parameter int DELAY_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_pop,
  input  pbts_pkg::pbts_cmd_t cmd,
  output logic                out_empty,
  input  logic                out_pop,
  output pbts_pkg::pbts_out_t out_item
);
  import pbts_pkg::*;

  localparam int IW = $clog2(PRIO_COUNT);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SWEEP = 3'b010,
    S_SCHED = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [PRIO_COUNT-1:0]   ready_r, ready_nxt;
  logic [PRIO_COUNT-1:0]   present_r, present_nxt;
  logic [7:0]              lock_r, lock_nxt;
  logic [4:0]              cur_prio_r, cur_prio_nxt;
  logic                    cur_vld_r, cur_vld_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;

  // Delay counters: a memory plus one written flag per entry, so that an
  // entry never written since reset reads as zero.
  logic [DELAY_WIDTH-1:0]  mem [PRIO_COUNT];
  logic [PRIO_COUNT-1:0]   dvld_r;
  logic [DELAY_WIDTH-1:0]  rd_data_r;
  logic                    rd_vld_r;
  logic                    mem_we;
  logic [IW-1:0]           mem_waddr;
  logic [DELAY_WIDTH-1:0]  mem_wdata;
  logic [IW-1:0]           mem_raddr;
  logic [DELAY_WIDTH-1:0]  eff_delay;

  logic                    out_vld_r;
  pbts_out_t               out_r;
  logic                    out_load;
  logic                    out_free;
  logic                    sw;
  logic [4:0]              np;
  logic                    nv;

  assign out_empty = !out_vld_r;
  assign out_item  = out_r;
  assign out_free  = !out_vld_r || out_pop;
  assign eff_delay = rd_vld_r ? rd_data_r : '0;

  // Lowest ready index.
  always_comb begin
    np = 5'd0;
    nv = 1'b0;
    for (int i = PRIO_COUNT - 1; i >= 0; i--) begin
      if (ready_r[i]) begin
        np = 5'(i);
        nv = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ready_nxt    = ready_r;
    present_nxt  = present_r;
    lock_nxt     = lock_r;
    cur_prio_nxt = cur_prio_r;
    cur_vld_nxt  = cur_vld_r;
    idx_nxt      = idx_r;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_raddr    = '0;
    cmd_pop      = 1'b0;
    out_load     = 1'b0;
    sw           = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_CREATE: begin
              present_nxt[cmd.prio[IW-1:0]] = 1'b1;
              ready_nxt[cmd.prio[IW-1:0]]   = 1'b1;
              mem_we    = 1'b1;
              mem_waddr = cmd.prio[IW-1:0];
              out_load  = 1'b1;
            end
            OP_TICK: begin
              idx_nxt   = '0;
              state_nxt = S_SWEEP;
            end
            OP_DELAY: begin
              if (cur_vld_r) begin
                mem_we    = 1'b1;
                mem_waddr = cur_prio_r[IW-1:0];
                mem_wdata = cmd.ticks[DELAY_WIDTH-1:0];
                ready_nxt[cur_prio_r[IW-1:0]] = 1'b0;
              end
              state_nxt = S_SCHED;
            end
            OP_LOCK: begin
              if (lock_r != LOCK_MAX) begin
                lock_nxt = lock_r + 8'd1;
              end
              out_load = 1'b1;
            end
            OP_UNLOCK: begin
              if (lock_r != 8'd0) begin
                lock_nxt = lock_r - 8'd1;
              end
              if (lock_r == 8'd1) begin
                state_nxt = S_SCHED;
              end else begin
                out_load = 1'b1;
              end
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      S_SWEEP: begin
        // rd_data_r holds entry idx_r; fetch the next one meanwhile.
        mem_raddr = IW'(idx_r + 1'b1);
        if (present_r[idx_r]) begin
          if (eff_delay != '0) begin
            mem_we    = 1'b1;
            mem_waddr = idx_r;
            mem_wdata = eff_delay - 1'b1;
          end else begin
            ready_nxt[idx_r] = 1'b1;
          end
        end
        if (idx_r == IW'(PRIO_COUNT - 1)) begin
          state_nxt = S_SCHED;
        end else begin
          idx_nxt = IW'(idx_r + 1'b1);
        end
      end
      S_SCHED: begin
        if (out_free) begin
          if (lock_r == 8'd0) begin
            sw           = (nv != cur_vld_r) || (nv && (np != cur_prio_r));
            cur_prio_nxt = np;
            cur_vld_nxt  = nv;
          end
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ready_r    <= '0;
      present_r  <= '0;
      lock_r     <= 8'd0;
      cur_prio_r <= 5'd0;
      cur_vld_r  <= 1'b0;
      idx_r      <= '0;
      dvld_r     <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ready_r    <= ready_nxt;
      present_r  <= present_nxt;
      lock_r     <= lock_nxt;
      cur_prio_r <= cur_prio_nxt;
      cur_vld_r  <= cur_vld_nxt;
      idx_r      <= idx_nxt;
      if (mem_we) begin
        dvld_r[mem_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
    rd_vld_r  <= dvld_r[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.run_prio   <= cur_prio_nxt;
      out_r.run_valid  <= cur_vld_nxt;
      out_r.switched   <= sw;
      out_r.lock_level <= lock_nxt;
      out_r.ready_mask <= 32'(ready_nxt);
    end
  end

endmodule

### sv/pbts_checker.sv
// Port-level checker for the priority bitmap task scheduler, bound to the
// top level below. Depends on pbts_pkg.
module pbts_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input pbts_pkg::pbts_out_t out_item
);
  import pbts_pkg::*;

  // Reset leaves both queues empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // A result that is not popped stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("waiting result changed");

  // The idle task always reports priority zero.
  a_idle_prio: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_item.run_valid) |-> (out_item.run_prio == 5'd0))
    else $error("idle result with nonzero priority");

  // A switch only happens with the scheduler unlocked.
  a_switch_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.switched) |-> (out_item.lock_level == 8'd0))
    else $error("switch reported while locked");

endmodule

bind priority_bitmap_task_scheduler pbts_checker u_pbts_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_full  (in_full),
  .out_empty(out_empty),
  .out_pop  (out_pop),
  .out_item (out_item)
);

### dv/priority_bitmap_task_scheduler_test.sv
// Self-checking testbench for priority_bitmap_task_scheduler.
// Depends on pbts_pkg for the item and result structs and the event kind codes.
// A built-in scheduler model predicts every result and checks it in order.
module priority_bitmap_task_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pbts_pkg::*;

  localparam int PRIO_COUNT  = 32;
  localparam int DELAY_WIDTH = 32;
  localparam logic [31:0] DELAY_MASK = 32'hFFFF_FFFF >> (32 - DELAY_WIDTH);

  // Kind codes the block must treat as no-ops.
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  localparam int RANDOM_EVENTS = 610;
  // The random stream gets a run of locks long enough to saturate the count.
  localparam int LOCK_BURST_AT  = 300;
  localparam int LOCK_BURST_LEN = 262;
  // Enough unlocks, beside the ticks mixed in, to bring the count back to zero.
  localparam int UNLOCK_BURST_LEN = 302;
  // The receiver stops popping for this long once, after this many results.
  localparam int STALL_AFTER  = 300;
  localparam int STALL_CYCLES = 400;
  // A tick walks every delay counter; this covers it with room to spare.
  localparam int DRAIN_CYCLES = PRIO_COUNT + 16;
  localparam int CYCLE_LIMIT  = 1000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  pbts_in_t  in_item = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  pbts_out_t out_item;

  priority_bitmap_task_scheduler #(
    .PRIO_COUNT (PRIO_COUNT),
    .DELAY_WIDTH(DELAY_WIDTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  always #1 clk = ~clk;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // An event waiting to be offered. When hold_for_idle is set, the sender
  // does not offer it until every earlier result has been popped and checked.
  typedef struct {
    pbts_in_t item;
    bit       hold_for_idle;
  } sched_event_t;

  sched_event_t pending_events[$];
  pbts_out_t    expected_results[$];

  int unsigned events_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned switches_seen   = 0;
  int unsigned peak_lock_seen  = 0;
  int unsigned error_count     = 0;
  int unsigned cycle_count     = 0;

  // -------------------------------------------------------------------------
  // Scheduler model. It holds its own copy of the bitmaps, the per-slot delay
  // counters, the lock depth and the running task, and is advanced once for
  // every item the block accepts.
  // -------------------------------------------------------------------------
  logic [31:0] ready_bits    = '0;
  logic [31:0] present_bits  = '0;
  logic [31:0] delay_count [PRIO_COUNT];
  logic [7:0]  lock_depth    = '0;
  logic [4:0]  running_prio  = '0;
  logic        running_valid = 1'b0;

  initial begin
    foreach (delay_count[i]) delay_count[i] = '0;
  end

  // Picks the lowest ready slot, or the idle task when none is ready.
  // While the scheduler is locked nothing changes. Returns whether the
  // running task changed.
  function automatic bit pick_lowest_ready();
    logic [4:0] next_prio;
    bit         next_valid;
    bit         changed;
    int         i;
    next_prio  = '0;
    next_valid = 1'b0;
    if (lock_depth != 0) return 1'b0;
    // Walking downward leaves the lowest ready index in next_prio.
    for (i = PRIO_COUNT - 1; i >= 0; i--) begin
      if (ready_bits[i]) begin
        next_prio  = 5'(i);
        next_valid = 1'b1;
      end
    end
    changed = (next_valid != running_valid) ||
              (next_valid && next_prio != running_prio);
    running_prio  = next_prio;
    running_valid = next_valid;
    return changed;
  endfunction

  // Applies one event to the model and returns the result it should produce.
  function automatic pbts_out_t schedule_event(pbts_in_t ev);
    pbts_out_t res;
    bit        sw;
    int        i;
    sw = 1'b0;
    case (ev.kind)
      KIND_CREATE: begin
        // Creating a slot again also clears its delay and makes it ready.
        if (int'(ev.prio) < PRIO_COUNT) begin
          present_bits[ev.prio] = 1'b1;
          ready_bits[ev.prio]   = 1'b1;
          delay_count[ev.prio]  = '0;
        end
      end
      KIND_TICK: begin
        // Only created slots are swept; a slot already at zero becomes ready.
        for (i = 0; i < PRIO_COUNT; i++) begin
          if (present_bits[i]) begin
            if (delay_count[i] != 0) delay_count[i] = (delay_count[i] - 1) & DELAY_MASK;
            else ready_bits[i] = 1'b1;
          end
        end
        sw = pick_lowest_ready();
      end
      KIND_DELAY: begin
        // With the idle task running there is nothing to delay, but the
        // reschedule still happens.
        if (running_valid) begin
          delay_count[running_prio] = ev.ticks & DELAY_MASK;
          ready_bits[running_prio]  = 1'b0;
        end
        sw = pick_lowest_ready();
      end
      KIND_LOCK: begin
        if (lock_depth < LOCK_MAX) lock_depth = lock_depth + 8'd1;
      end
      KIND_UNLOCK: begin
        // An unlock at zero is ignored; only the last release reschedules.
        if (lock_depth != 0) begin
          lock_depth = lock_depth - 8'd1;
          if (lock_depth == 0) sw = pick_lowest_ready();
        end
      end
      default: begin
      end
    endcase
    res.run_prio   = running_prio;
    res.run_valid  = running_valid;
    res.switched   = sw;
    res.lock_level = lock_depth;
    res.ready_mask = ready_bits;
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Idle-time draw shared by both sides. Most of the time a side waits a
  // random idle time per item, but now and then it enters a calm stretch
  // where it waits not at all, so that back-to-back traffic is exercised too.
  // -------------------------------------------------------------------------
  function automatic int unsigned pick_wait(inout int unsigned calm_left);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 50);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  task automatic queue_event(input logic [2:0] kind, input logic [4:0] prio,
                             input logic [31:0] ticks, input bit hold_for_idle);
    sched_event_t ev;
    ev.item.kind     = kind;
    ev.item.prio     = prio;
    ev.item.ticks    = ticks;
    ev.hold_for_idle = hold_for_idle;
    pending_events.push_back(ev);
  endtask

  // -------------------------------------------------------------------------
  // Driver. At each rising edge it first notes whether the item on the port
  // was taken; a taken item is run through the model right away, so the
  // expected results stay in acceptance order. Then it decides what the port
  // shows for the next edge. in_push and in_item get at most one
  // nonblocking assignment per edge, so a valid that stays high between
  // back-to-back items is never lowered and raised in the same step.
  // -------------------------------------------------------------------------
  int unsigned  send_wait = 0;
  int unsigned  send_calm = 0;

  always @(posedge clk) begin : drive_events
    bit           taken;
    sched_event_t next_ev;
    if (!rst_n) begin
      in_push <= 1'b0;
      in_item <= '0;
    end else begin
      taken = in_push && !in_full;
      if (taken) begin
        expected_results.push_back(schedule_event(in_item));
        events_accepted++;
        send_wait = pick_wait(send_calm);
      end
      // An item that was offered but not taken stays on the port unchanged.
      if (!in_push || taken) begin
        if (send_wait != 0) begin
          send_wait--;
          in_push <= 1'b0;
        end else if (pending_events.size() != 0 &&
                     (!pending_events[0].hold_for_idle || expected_results.size() == 0)) begin
          next_ev = pending_events.pop_front();
          in_item <= next_ev.item;
          in_push <= 1'b1;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver hold-off. Once, after STALL_AFTER results, the receiver stops
  // popping for the stretch set by STALL_CYCLES while the driver keeps
  // offering items, so the block backs up all the way to in_full.
  // -------------------------------------------------------------------------
  int unsigned stall_left = 0;
  bit          stall_done = 1'b0;

  always @(posedge clk) begin : hold_off
    if (!rst_n) begin
      stall_left <= 0;
    end else if (!stall_done && results_checked >= STALL_AFTER) begin
      stall_left <= STALL_CYCLES;
      stall_done = 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // -------------------------------------------------------------------------
  // Monitor. A result taken at this edge is checked field by field against
  // the oldest prediction.
  // -------------------------------------------------------------------------
  int unsigned pop_wait   = 0;
  int unsigned pop_calm   = 0;

  always @(posedge clk) begin : check_results
    pbts_out_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result run_prio=%0d run_valid=%0d switched=%0d lock=%0d ready=%h",
                   $time, out_item.run_prio, out_item.run_valid, out_item.switched,
                   out_item.lock_level, out_item.ready_mask);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_item.run_prio !== want.run_prio) begin
            $display("%0t: run_prio mismatch: expected %0d, actual %0d",
                     $time, want.run_prio, out_item.run_prio);
            error_count++;
          end
          if (out_item.run_valid !== want.run_valid) begin
            $display("%0t: run_valid mismatch: expected %0d, actual %0d",
                     $time, want.run_valid, out_item.run_valid);
            error_count++;
          end
          if (out_item.switched !== want.switched) begin
            $display("%0t: switched mismatch: expected %0d, actual %0d",
                     $time, want.switched, out_item.switched);
            error_count++;
          end
          if (out_item.lock_level !== want.lock_level) begin
            $display("%0t: lock_level mismatch: expected %0d, actual %0d",
                     $time, want.lock_level, out_item.lock_level);
            error_count++;
          end
          if (out_item.ready_mask !== want.ready_mask) begin
            $display("%0t: ready_mask mismatch: expected %h, actual %h",
                     $time, want.ready_mask, out_item.ready_mask);
            error_count++;
          end
        end
        results_checked++;
        if (out_item.switched === 1'b1) switches_seen++;
        if (int'(out_item.lock_level) > peak_lock_seen) peak_lock_seen = out_item.lock_level;
        pop_wait = pick_wait(pop_calm);
      end
      if (stall_left != 0) begin
        out_pop <= 1'b0;
      end else if (pop_wait != 0) begin
        pop_wait--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // A hung block or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still expected", $time, expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus and end of test. The directed part walks the special cases in
  // order from a fresh reset; the random part follows.
  // -------------------------------------------------------------------------
  initial begin : stimulus
    int          n;
    int          k;
    int unsigned pick;
    logic [2:0]  kind;
    logic [31:0] ticks;

    // Delay, tick and unlock with nothing created and the idle task running.
    queue_event(KIND_DELAY, 5'd0, 32'd5, 1'b0);
    queue_event(KIND_TICK, 5'd0, 32'd0, 1'b0);
    queue_event(KIND_UNLOCK, 5'd0, 32'd0, 1'b0);
    // Unused kinds must change nothing, whatever the other fields hold.
    for (k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
      queue_event(3'(k), 5'd31, 32'hFFFF_FFFF, 1'b0);
    // Lowest and highest slots; create does not reschedule, the tick does.
    queue_event(KIND_CREATE, 5'd31, 32'hFFFF_FFFF, 1'b0);
    queue_event(KIND_CREATE, 5'd0, 32'd0, 1'b0);
    queue_event(KIND_TICK, 5'd0, 32'd0, 1'b0);
    // A zero delay drops slot 0 until the next tick brings it back.
    queue_event(KIND_DELAY, 5'd0, 32'd0, 1'b0);
    queue_event(KIND_TICK, 5'd0, 32'd0, 1'b0);
    // A maximum delay parks slot 0; creating it again releases it.
    queue_event(KIND_DELAY, 5'd0, 32'hFFFF_FFFF, 1'b0);
    queue_event(KIND_CREATE, 5'd0, 32'd0, 1'b0);
    // Nested lock: nothing reschedules until the last unlock.
    queue_event(KIND_LOCK, 5'd0, 32'd0, 1'b0);
    queue_event(KIND_LOCK, 5'd0, 32'd0, 1'b0);
    queue_event(KIND_TICK, 5'd0, 32'd0, 1'b0);
    queue_event(KIND_DELAY, 5'd0, 32'd3, 1'b0);
    queue_event(KIND_UNLOCK, 5'd0, 32'd0, 1'b0);
    queue_event(KIND_UNLOCK, 5'd0, 32'd0, 1'b0);
    // A short delay counts down over several ticks.
    queue_event(KIND_DELAY, 5'd0, 32'd2, 1'b0);
    queue_event(KIND_TICK, 5'd0, 32'd0, 1'b0);
    queue_event(KIND_TICK, 5'd0, 32'd0, 1'b0);
    queue_event(KIND_TICK, 5'd0, 32'd0, 1'b0);
    queue_event(KIND_CREATE, 5'd15, 32'd0, 1'b0);

    // Random part. Delays are mostly short so that slots keep cycling
    // between blocked and ready; unlocks outnumber locks so the scheduler
    // is usually free to switch. The first random item waits for the block
    // to drain completely.
    for (n = 0; n < RANDOM_EVENTS; n++) begin
      if (n == LOCK_BURST_AT) begin
        // Drive the lock count into saturation and back down to zero.
        for (k = 0; k < LOCK_BURST_LEN; k++)
          queue_event(KIND_LOCK, 5'($urandom), $urandom, k == 0);
        for (k = 0; k < UNLOCK_BURST_LEN; k++)
          queue_event((k % 8 == 3) ? KIND_TICK : KIND_UNLOCK, 5'($urandom), $urandom, 1'b0);
      end
      pick  = $urandom_range(0, 99);
      ticks = $urandom;
      if (pick < 14) begin
        kind = KIND_CREATE;
      end else if (pick < 50) begin
        kind = KIND_TICK;
      end else if (pick < 72) begin
        kind = KIND_DELAY;
        pick = $urandom_range(0, 9);
        if (pick < 7) ticks = $urandom_range(0, 6);
        else if (pick < 9) ticks = $urandom_range(7, 40);
      end else if (pick < 80) begin
        kind = KIND_LOCK;
      end else if (pick < 94) begin
        kind = KIND_UNLOCK;
      end else begin
        kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      end
      queue_event(kind, 5'($urandom), ticks, n == 0);
    end

    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (pending_events.size() != 0 || in_push) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    // Give a stray extra result time to show up before judging the run.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results for %0d events: %0d task switches, peak lock depth %0d.",
             results_checked, events_accepted, switches_seen, peak_lock_seen);
    $display("Covered create, tick, delay, lock, unlock, unused kinds and a %0d-cycle receiver stall.",
             STALL_CYCLES);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/pbts_pkg.sv
sv/pbts_front.sv
sv/pbts_back.sv
sv/priority_bitmap_task_scheduler.sv
sv/pbts_checker.sv
dv/priority_bitmap_task_scheduler_test.sv
